FILE: design/dad_pkg.sv
package dad_pkg;

	localparam int YEAR_BITS = 16;
	localparam int ADD_BITS  = 16;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;

	localparam logic [MONTH_W-1:0] JAN_MONTH = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEB_MONTH = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] JUL_MONTH = MONTH_W'(7);
	localparam logic [MONTH_W-1:0] DEC_MONTH = MONTH_W'(12);

	localparam logic [DAY_W-1:0] FIRST_DAY    = DAY_W'(1);
	localparam logic [DAY_W-1:0] FEB_LEAP_LEN = DAY_W'(29);
	localparam logic [DAY_W-1:0] FEB_LEN      = DAY_W'(28);
	localparam logic [DAY_W-1:0] LONG_LEN     = DAY_W'(31);
	localparam logic [DAY_W-1:0] SHORT_LEN    = DAY_W'(30);

	typedef struct packed {
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_BITS-1:0] year;
		logic [ADD_BITS-1:0]  rem;
	} date_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DONE
	} state_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		if (month == FEB_MONTH) begin
			len = leap ? FEB_LEAP_LEN : FEB_LEN;
		end else if (month <= JUL_MONTH) begin
			len = month[0] ? LONG_LEN : SHORT_LEN;
		end else begin
			len = month[0] ? SHORT_LEN : LONG_LEN;
		end
		return len;
	endfunction

endpackage

FILE: design/dad_step.sv
module dad_step (
	input  dad_pkg::date_t cur,
	output dad_pkg::date_t nxt,
	output logic           fin,
	output logic           wrap
);
	import dad_pkg::*;

	logic [DAY_W-1:0] len;
	logic [DAY_W-1:0] left;

	always_comb begin
		len  = month_len(cur.month, cur.year[1:0] == 2'b00);
		left = len - cur.day;
		fin  = (ADD_BITS+DAY_W)'(left) >= (ADD_BITS+DAY_W)'(cur.rem);
		wrap = 1'b0;
		nxt  = cur;
		if (fin) begin
			// remaining count fits in this month
			nxt.day = cur.day + DAY_W'(cur.rem);
			nxt.rem = '0;
		end else begin
			nxt.day = FIRST_DAY;
			nxt.rem = cur.rem - ADD_BITS'(left) - ADD_BITS'(1);
			if (cur.month != DEC_MONTH) begin
				nxt.month = cur.month + MONTH_W'(1);
			end else begin
				nxt.month = JAN_MONTH;
				nxt.year  = cur.year + YEAR_BITS'(1);
				wrap      = &cur.year;
			end
		end
	end

endmodule

FILE: design/date_add_days.sv
// channel | handshake             | payload
// in      | in_valid / in_stall   | start_day, start_month, start_year, days_to_add
// out     | out_valid / out_stall | end_day, end_month, end_year, date_valid, year_overflow
//
// a valid date passes the check and then takes one month step a cycle in ST_RUN
// (up to about 2160 months for a 16-bit count); an invalid date goes from check to result
// in_stall is high from the input transfer until the result transfer
// the result holds steady in its registers while out_stall is high
// arst_n clears the sequencer, nothing is pending after reset
module date_add_days (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [4:0]                   start_day,
	input  logic [3:0]                   start_month,
	input  logic [15:0]                  start_year,
	input  logic [15:0]                  days_to_add,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [4:0]                   end_day,
	output logic [3:0]                   end_month,
	output logic [15:0]                  end_year,
	output logic                         date_valid,
	output logic                         year_overflow
);
	import dad_pkg::*;

	state_t state_q;
	state_t state_d;
	date_t  cur_q;
	date_t  nxt;
	logic   fin;
	logic   wrap;
	logic   valid_q;
	logic   ovf_q;
	logic   chk_ok;

	dad_step u_step (
		.cur  (cur_q),
		.nxt  (nxt),
		.fin  (fin),
		.wrap (wrap)
	);

	assign chk_ok = (cur_q.month >= JAN_MONTH) && (cur_q.month <= DEC_MONTH) &&
		(cur_q.day >= FIRST_DAY) &&
		(cur_q.day <= month_len(cur_q.month, cur_q.year[1:0] == 2'b00));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = chk_ok ? ST_RUN : ST_DONE;
			end
			ST_RUN: begin
				if (fin) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall  = 1'b0;
			ST_DONE:  out_valid = 1'b1;
			default: begin
				in_stall  = 1'b1;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cur_q.day   <= start_day;
			cur_q.month <= start_month;
			cur_q.year  <= YEAR_BITS'(start_year);
			cur_q.rem   <= ADD_BITS'(days_to_add);
			ovf_q       <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			valid_q <= chk_ok;
		end else if (state_q == ST_RUN) begin
			cur_q <= nxt;
			if (wrap) ovf_q <= 1'b1;
		end
	end

	assign end_day       = cur_q.day;
	assign end_month     = cur_q.month;
	assign end_year      = 16'(cur_q.year);
	assign date_valid    = valid_q;
	assign year_overflow = ovf_q;

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("result shown right after input transfer");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !fin) |=> (cur_q.rem < $past(cur_q.rem)))
		else $error("remaining count did not shrink on a month step");

	a_invalid_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !date_valid) |-> !year_overflow)
		else $error("overflow flagged on an invalid date");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && date_valid) |->
		(end_month >= JAN_MONTH && end_month <= DEC_MONTH && end_day >= FIRST_DAY))
		else $error("result date out of range");

endmodule
